@@ rtl/core/sqld_pkg.sv @@
// ----------------------------------------------------------------------------
// sqld_pkg
// Types, constants and mask functions shared by the lift/drop detector.
// ----------------------------------------------------------------------------
package sqld_pkg;

  localparam int unsigned OccW   = 64;  // one bit per square, fixed 8x8 layout
  localparam int unsigned RowW   = 8;   // bit stride between ranks
  localparam int unsigned CoordW = 3;   // rank or file index

  typedef logic [OccW-1:0]   occ_t;
  typedef logic [CoordW-1:0] coord_t;

  // First changed square found by a scan
  typedef struct packed {
    logic   found;
    coord_t rank;
    coord_t file;
  } sqld_hit_t;

  // One result beat
  typedef struct packed {
    logic   pickup_seen;
    coord_t pickup_rank;
    coord_t pickup_column;
    logic   drop_seen;
    coord_t drop_rank;
    coord_t drop_column;
    logic   home_layout;
  } sqld_result_t;

  // Squares that lie inside a side x side grid
  function automatic occ_t grid_mask(input int unsigned side);
    occ_t m;
    m = '0;
    for (int unsigned r = 0; r < RowW; r++) begin
      for (int unsigned f = 0; f < RowW; f++) begin
        if (r < side && f < side) begin
          m[r*RowW+f] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  // Starting layout: two back ranks on each side full, the rest empty
  function automatic occ_t home_mask(input int unsigned side);
    occ_t m;
    m = '0;
    for (int unsigned r = 0; r < RowW; r++) begin
      for (int unsigned f = 0; f < RowW; f++) begin
        if (r < side && f < side && (r <= 1 || r + 2 >= side)) begin
          m[r*RowW+f] = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

@@ rtl/core/sqld_first_square.sv @@
// ----------------------------------------------------------------------------
// sqld_first_square
// Two-level priority encoder: lowest rank with a set bit, then lowest file.
// ----------------------------------------------------------------------------
module sqld_first_square (
  input  sqld_pkg::occ_t    vec_i,
  output sqld_pkg::sqld_hit_t hit_o
);

  logic [sqld_pkg::RowW-1:0] rank_any;
  logic [sqld_pkg::RowW-1:0] rank_bits;
  sqld_pkg::coord_t          rank_sel;
  sqld_pkg::coord_t          file_sel;

  always_comb begin
    for (int r = 0; r < sqld_pkg::RowW; r++) begin
      rank_any[r] = |vec_i[r*sqld_pkg::RowW +: sqld_pkg::RowW];
    end
  end

  // scan downwards so the lowest set rank wins
  always_comb begin
    rank_sel = '0;
    for (int r = sqld_pkg::RowW - 1; r >= 0; r--) begin
      if (rank_any[r]) begin
        rank_sel = sqld_pkg::CoordW'(r);
      end
    end
  end

  assign rank_bits = vec_i[rank_sel*sqld_pkg::RowW +: sqld_pkg::RowW];

  always_comb begin
    file_sel = '0;
    for (int f = sqld_pkg::RowW - 1; f >= 0; f--) begin
      if (rank_bits[f]) begin
        file_sel = sqld_pkg::CoordW'(f);
      end
    end
  end

  assign hit_o.found = |rank_any;
  assign hit_o.rank  = rank_sel;
  assign hit_o.file  = file_sel;

endmodule

@@ rtl/core/sqld_eval.sv @@
// ----------------------------------------------------------------------------
// sqld_eval
// Holds the stored snapshot and lifted flag; works out one result per beat.
// ----------------------------------------------------------------------------
module sqld_eval (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  sqld_pkg::occ_t         board_i,
  input  logic                   home_i,
  output sqld_pkg::sqld_result_t result_o
);

  sqld_pkg::occ_t      current_q;
  logic                lifted_q;
  logic                lifted_d;
  sqld_pkg::occ_t      gone;
  sqld_pkg::occ_t      came;
  sqld_pkg::sqld_hit_t pick_hit;
  sqld_pkg::sqld_hit_t drop_hit;
  logic                armed;

  assign gone = current_q & ~board_i;
  assign came = ~current_q & board_i;

  sqld_first_square u_pick (
    .vec_i (gone),
    .hit_o (pick_hit)
  );

  sqld_first_square u_drop (
    .vec_i (came),
    .hit_o (drop_hit)
  );

  // pickup is checked first, so it can arm the drop in the same beat
  assign armed = lifted_q | pick_hit.found;

  always_comb begin
    result_o.pickup_seen   = pick_hit.found;
    result_o.pickup_rank   = pick_hit.found ? pick_hit.rank : '0;
    result_o.pickup_column = pick_hit.found ? pick_hit.file : '0;
    result_o.drop_seen     = armed & drop_hit.found;
    result_o.drop_rank     = (armed & drop_hit.found) ? drop_hit.rank : '0;
    result_o.drop_column   = (armed & drop_hit.found) ? drop_hit.file : '0;
    result_o.home_layout   = home_i;
    lifted_d               = armed & ~drop_hit.found;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_q <= '0;
      lifted_q  <= 1'b0;
    end else if (take_i) begin
      current_q <= board_i;
      lifted_q  <= lifted_d;
    end
  end

  a_drop_needs_lift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && result_o.drop_seen |-> lifted_q || result_o.pickup_seen)
    else $error("drop reported without a lift");

  a_drop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && result_o.drop_seen |=> !lifted_q)
    else $error("lifted flag not cleared by drop");

  a_pick_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && result_o.pickup_seen && !result_o.drop_seen |=> lifted_q)
    else $error("lifted flag not set by pickup");

  a_pick_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && result_o.pickup_seen |->
      gone[{result_o.pickup_rank, result_o.pickup_column}])
    else $error("pickup square did not empty");

endmodule

@@ rtl/core/square_matrix_lift_drop_detector.sv @@
// ----------------------------------------------------------------------------
// square_matrix_lift_drop_detector
// Finds the first lifted and first dropped square between sensor polls.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------
//   in      | input     | in_valid_i / in_ready_o  | occupancy_i
//   out     | output    | out_valid_o / out_ready_i| pickup_*, drop_*, home
//
// One snapshot per cycle sustained while the output is not stalled; a result
// passes from the input register to the result register and is then valid.
// Both priority encoders sit between the input and result registers.
// Reset clears the stored board, the lifted flag and both valid bits.
// A stalled output holds its beat; the input register still takes one more.
// ----------------------------------------------------------------------------
module square_matrix_lift_drop_detector #(
  parameter int unsigned BOARD_SIDE = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [63:0]              occupancy_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     pickup_seen_o,
  output logic [2:0]               pickup_rank_o,
  output logic [2:0]               pickup_column_o,
  output logic                     drop_seen_o,
  output logic [2:0]               drop_rank_o,
  output logic [2:0]               drop_column_o,
  output logic                     home_layout_o
);

  localparam sqld_pkg::occ_t GridMask = sqld_pkg::grid_mask(BOARD_SIDE);
  localparam sqld_pkg::occ_t HomeMask = sqld_pkg::home_mask(BOARD_SIDE);

  logic                   s1_valid_q;
  sqld_pkg::occ_t         s1_board_q;
  sqld_pkg::occ_t         s1_board_d;
  logic                   s1_home_q;
  logic                   s1_adv;
  logic                   in_take;
  logic                   out_valid_q;
  sqld_pkg::sqld_result_t result_d;
  sqld_pkg::sqld_result_t result_q;

  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_adv;
  assign in_take    = in_valid_i & in_ready_o;

  // drop squares outside the grid before they reach the stored board
  assign s1_board_d = occupancy_i & GridMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_board_q <= s1_board_d;
      s1_home_q  <= (s1_board_d == HomeMask);
    end
  end

  sqld_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (s1_adv),
    .board_i  (s1_board_q),
    .home_i   (s1_home_q),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pickup_seen_o   = result_q.pickup_seen;
  assign pickup_rank_o   = result_q.pickup_rank;
  assign pickup_column_o = result_q.pickup_column;
  assign drop_seen_o     = result_q.drop_seen;
  assign drop_rank_o     = result_q.drop_rank;
  assign drop_column_o   = result_q.drop_column;
  assign home_layout_o   = result_q.home_layout;

endmodule
